>>> sv/pdup_pkg.sv
// Shared types and codes for the per-device uplink policer.
package pdup_pkg;

    localparam int ADDR_W   = 32;
    localparam int PRIO_W   = 8;
    localparam int BYTES_W  = 8;
    localparam int HOUR_W   = 8;
    localparam int BUDGET_W = 18;
    localparam int RATE_W   = 16;
    localparam int MODE_W   = 3;

    localparam logic [BUDGET_W-1:0] BUDGET_FLOOR = {1'b1, {(BUDGET_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_BEST   = 2'd1,
        OP_FILTER = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    localparam logic [MODE_W-1:0] MODE_OFF      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BEST     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PRIORITY = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BYTES    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PACKETS  = 3'd4;

    localparam logic [7:0] CFG_FILTER_MODE      = 8'd0;
    localparam logic [7:0] CFG_PRIORITY_LEVEL   = 8'd1;
    localparam logic [7:0] CFG_BYTES_PER_HOUR   = 8'd2;
    localparam logic [7:0] CFG_PACKETS_PER_HOUR = 8'd3;

    typedef enum logic [1:0] {
        UPD_NONE   = 2'd0,
        UPD_ADD    = 2'd1,
        UPD_BEST   = 2'd2,
        UPD_FILTER = 2'd3
    } upd_kind_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PRIO_W-1:0] level;
        logic [RATE_W-1:0] bytes_per_hour;
        logic [RATE_W-1:0] packets_per_hour;
    } cfg_t;

    // Lookup result for the item in the input stage.
    typedef struct packed {
        logic                found;
        logic                free_found;
        logic [PRIO_W-1:0]   prio;
        logic                best;
        logic [BUDGET_W-1:0] byte_budget;
        logic [BUDGET_W-1:0] pkt_budget;
        logic [HOUR_W-1:0]   last_hour;
        logic                seen;
    } match_t;

    // Write command into the entry table.
    typedef struct packed {
        upd_kind_t           kind;
        logic [ADDR_W-1:0]   addr;
        logic [PRIO_W-1:0]   prio;
        logic [BUDGET_W-1:0] byte_budget;
        logic [BUDGET_W-1:0] pkt_budget;
        logic [HOUR_W-1:0]   last_hour;
        logic                seen;
    } upd_t;

    typedef struct packed {
        logic allowed;
        logic found;
        logic full;
    } res_t;

endpackage

>>> sv/pdup_table.sv
// Device entry table: parallel address match, free-slot search and entry writes.
module pdup_table
    import pdup_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int IDX_W       = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [ADDR_W-1:0] lookup_addr,
    output match_t            match,
    output logic [IDX_W-1:0]  match_idx,
    output logic [IDX_W-1:0]  free_idx,
    input  upd_t              upd,
    input  logic [IDX_W-1:0]  upd_idx
);

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] best_reg;
    logic [TABLE_DEPTH-1:0] seen_reg;
    logic [ADDR_W-1:0]      addr_reg   [TABLE_DEPTH];
    logic [PRIO_W-1:0]      prio_reg   [TABLE_DEPTH];
    logic [BUDGET_W-1:0]    bbud_reg   [TABLE_DEPTH];
    logic [BUDGET_W-1:0]    pbud_reg   [TABLE_DEPTH];
    logic [HOUR_W-1:0]      hour_reg   [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] hit;
    logic [TABLE_DEPTH-1:0] free_vec;
    logic [TABLE_DEPTH-1:0] free_first;

    // Addresses among valid entries are unique, so at most one hit.
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            hit[i] = valid_reg[i] && (addr_reg[i] == lookup_addr);
        end
        free_vec   = ~valid_reg;
        free_first = free_vec & (~free_vec + {{(TABLE_DEPTH-1){1'b0}}, 1'b1});
    end

    always_comb begin
        match     = '0;
        match_idx = '0;
        free_idx  = '0;
        match.found      = |hit;
        match.free_found = |free_vec;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (hit[i]) begin
                match_idx         = match_idx | IDX_W'(i);
                match.prio        = match.prio | prio_reg[i];
                match.best        = match.best | best_reg[i];
                match.byte_budget = match.byte_budget | bbud_reg[i];
                match.pkt_budget  = match.pkt_budget | pbud_reg[i];
                match.last_hour   = match.last_hour | hour_reg[i];
                match.seen        = match.seen | seen_reg[i];
            end
            if (free_first[i]) begin
                free_idx = free_idx | IDX_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            best_reg  <= '0;
            seen_reg  <= '0;
        end else begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (upd_idx == IDX_W'(i)) begin
                    case (upd.kind)
                        UPD_ADD: begin
                            valid_reg[i] <= 1'b1;
                            best_reg[i]  <= 1'b0;
                            seen_reg[i]  <= 1'b0;
                        end
                        UPD_BEST: begin
                            best_reg[i] <= 1'b1;
                        end
                        UPD_FILTER: begin
                            seen_reg[i] <= upd.seen;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    // Payload fields: no reset, only read once the entry is valid.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (upd_idx == IDX_W'(i)) begin
                case (upd.kind)
                    UPD_ADD: begin
                        addr_reg[i] <= upd.addr;
                        prio_reg[i] <= upd.prio;
                        bbud_reg[i] <= upd.byte_budget;
                        pbud_reg[i] <= upd.pkt_budget;
                        hour_reg[i] <= '0;
                    end
                    UPD_FILTER: begin
                        bbud_reg[i] <= upd.byte_budget;
                        pbud_reg[i] <= upd.pkt_budget;
                        hour_reg[i] <= upd.last_hour;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

>>> sv/pdup_policy.sv
// Per-item decision logic: add, mark best, and the five filter modes.
module pdup_policy
    import pdup_pkg::*;
#(
    parameter int IDX_W = 5
) (
    input  op_t                op,
    input  logic [ADDR_W-1:0]  addr,
    input  logic [PRIO_W-1:0]  prio,
    input  logic [BYTES_W-1:0] pkt_bytes,
    input  logic [HOUR_W-1:0]  hour,
    input  logic               tzero,
    input  cfg_t               cfg,
    input  match_t             match,
    input  logic [IDX_W-1:0]   match_idx,
    input  logic [IDX_W-1:0]   free_idx,
    output res_t               res,
    output upd_t               upd,
    output logic [IDX_W-1:0]   upd_idx
);

    logic                reload;
    logic [BUDGET_W-1:0] bbase;
    logic [BUDGET_W-1:0] pbase;
    logic [BUDGET_W:0]   bdiff;
    logic [BUDGET_W:0]   pdiff;
    logic [BUDGET_W-1:0] bnew;
    logic [BUDGET_W-1:0] pnew;

    // Budget spend with saturation at the most negative value.
    always_comb begin
        reload = match.seen && (match.last_hour != hour);
        bbase  = reload ? BUDGET_W'(cfg.bytes_per_hour) : match.byte_budget;
        pbase  = reload ? BUDGET_W'(cfg.packets_per_hour) : match.pkt_budget;
        bdiff  = {bbase[BUDGET_W-1], bbase} - (BUDGET_W+1)'(pkt_bytes);
        pdiff  = {pbase[BUDGET_W-1], pbase} - (BUDGET_W+1)'(1);
        bnew   = (bdiff[BUDGET_W] != bdiff[BUDGET_W-1]) ? BUDGET_FLOOR : bdiff[BUDGET_W-1:0];
        pnew   = (pdiff[BUDGET_W] != pdiff[BUDGET_W-1]) ? BUDGET_FLOOR : pdiff[BUDGET_W-1:0];
    end

    always_comb begin
        res             = '{allowed: 1'b1, found: 1'b0, full: 1'b0};
        upd             = '0;
        upd.kind        = UPD_NONE;
        upd.addr        = addr;
        upd.prio        = prio;
        upd.last_hour   = hour;
        upd.seen        = !tzero;
        upd.byte_budget = match.byte_budget;
        upd.pkt_budget  = match.pkt_budget;
        upd_idx         = match_idx;
        case (op)
            OP_ADD: begin
                res.found       = match.found;
                upd.byte_budget = BUDGET_W'(cfg.bytes_per_hour);
                upd.pkt_budget  = BUDGET_W'(cfg.packets_per_hour);
                if (match.found) begin
                    upd.kind = UPD_ADD;
                end else if (match.free_found) begin
                    upd.kind = UPD_ADD;
                    upd_idx  = free_idx;
                end else begin
                    res.full = 1'b1;
                end
            end
            OP_BEST: begin
                res.found = match.found;
                if (match.found) begin
                    upd.kind = UPD_BEST;
                end
            end
            OP_FILTER: begin
                res.found = match.found;
                case (cfg.mode)
                    MODE_BEST: begin
                        res.allowed = match.found && match.best;
                    end
                    MODE_PRIORITY: begin
                        res.allowed = !(match.found && (match.prio > cfg.level));
                    end
                    MODE_BYTES: begin
                        if (match.found) begin
                            upd.kind        = UPD_FILTER;
                            upd.byte_budget = bnew;
                            res.allowed     = !bnew[BUDGET_W-1];
                        end
                    end
                    MODE_PACKETS: begin
                        if (match.found) begin
                            upd.kind       = UPD_FILTER;
                            upd.pkt_budget = pnew;
                            res.allowed    = !pnew[BUDGET_W-1];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

endmodule

>>> sv/per_device_uplink_policer.sv
// Top level of the per-device uplink policer: stream ports, config and stage registers.
//
// Uplink filter with a table of TABLE_DEPTH end devices held in flip-flops and
// matched in parallel by 32-bit address. Each transfer on the s_ channel is one
// operation (add device, mark best gateway, filter packet) and yields exactly one
// result transfer on m_. Throughput is one item per cycle unless m_tready stalls the
// result register. From input transfer to m_tvalid: input register, then the address
// match, decision and entry write all settle in one pass ahead of the result register.
// The entry write lands at the same edge the result is registered, so the next item
// always sees the updated table. No clearing pass is needed after reset: valid,
// best and seen bits reset directly. Config writes (cfg_ready is always high) must
// only happen while no item is in flight.
module per_device_uplink_policer
    import pdup_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata, lowest bit up: device_address[31:0], device_priority[39:32],
    // packet_bytes[47:40], hour_now[55:48], time_is_zero[56], zero pad[63:57]
    input  logic [63:0] s_tdata,
    // s_tuser: operation[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata, lowest bit up: allowed[0], device_found[1], table_full[2], zero pad[7:3]
    output logic [7:0]  m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Config registers
    cfg_t cfg_reg;

    // Input stage
    logic               in_valid_reg;
    op_t                op_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [PRIO_W-1:0]  prio_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [HOUR_W-1:0]  hour_reg;
    logic               tzero_reg;

    // Result stage
    logic out_valid_reg;
    res_t res_reg;

    logic             out_free;
    logic             advance;
    match_t           match;
    logic [IDX_W-1:0] match_idx;
    logic [IDX_W-1:0] free_idx;
    res_t             res_next;
    upd_t             upd_raw;
    upd_t             upd;
    logic [IDX_W-1:0] upd_idx;

    // Output register empties or drains this cycle -> the input stage may move on.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, res_reg.full, res_reg.found, res_reg.allowed};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode             <= MODE_BEST;
            cfg_reg.level            <= 8'd1;
            cfg_reg.bytes_per_hour   <= 16'd19;
            cfg_reg.packets_per_hour <= 16'd1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FILTER_MODE:      cfg_reg.mode             <= cfg_data[MODE_W-1:0];
                CFG_PRIORITY_LEVEL:   cfg_reg.level            <= cfg_data[PRIO_W-1:0];
                CFG_BYTES_PER_HOUR:   cfg_reg.bytes_per_hour   <= cfg_data;
                CFG_PACKETS_PER_HOUR: cfg_reg.packets_per_hour <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input stage payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg    <= op_t'(s_tuser);
            addr_reg  <= s_tdata[31:0];
            prio_reg  <= s_tdata[39:32];
            bytes_reg <= s_tdata[47:40];
            hour_reg  <= s_tdata[55:48];
            tzero_reg <= s_tdata[56];
        end
    end

    pdup_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_table (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .lookup_addr (addr_reg),
        .match       (match),
        .match_idx   (match_idx),
        .free_idx    (free_idx),
        .upd         (upd),
        .upd_idx     (upd_idx)
    );

    pdup_policy #(
        .IDX_W (IDX_W)
    ) u_policy (
        .op        (op_reg),
        .addr      (addr_reg),
        .prio      (prio_reg),
        .pkt_bytes (bytes_reg),
        .hour      (hour_reg),
        .tzero     (tzero_reg),
        .cfg       (cfg_reg),
        .match     (match),
        .match_idx (match_idx),
        .free_idx  (free_idx),
        .res       (res_next),
        .upd       (upd_raw),
        .upd_idx   (upd_idx)
    );

    // Table writes only when the item actually leaves the input stage.
    always_comb begin
        upd = upd_raw;
        if (!advance) begin
            upd.kind = UPD_NONE;
        end
    end

    // Result stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result stage payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    // An empty result register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low while result register empty");

    // A failed add reports neither a match nor a drop.
    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> (!m_tdata[1] && m_tdata[0]))
        else $error("table_full result with device_found or drop");

    // Only filter operations can drop.
    a_drop_only_filter: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (op_reg != OP_FILTER)) |-> res_next.allowed)
        else $error("non-filter operation dropped");

    // Table writes only happen when an item is consumed.
    a_write_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd.kind != UPD_NONE) |-> (in_valid_reg && out_free))
        else $error("table write without a consumed item");

endmodule
